// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the voice allocator.
// Depends on nothing; each macro samples on clk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising edge of clk
`define SVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define SVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sva_pkg.sv =====
// Shared types and constants of the sound voice allocator.
// Used by the top level, the checker; depends on nothing.
`timescale 1ns / 1ps

package sva_pkg;

  localparam int NUM_VOICES = 8;
  localparam int IDX_W      = $clog2(NUM_VOICES);
  localparam int CNT_W      = IDX_W + 1;

  // volume scale: q = floor((vol*cat*duck*gain >> 8) / 65025), taken as
  // (x * (2^32 + RECIP_FRAC)) >> 48, exact for every x below 2^32
  localparam logic [25:0] RECIP_FRAC  = 26'd33752070;
  localparam logic [39:0] SAT_LIMIT   = 40'd4261478400;

  localparam logic [6:0]        PAN_CENTRE     = 7'd64;
  localparam logic signed [15:0] MUSIC_PRIORITY = 16'sd8;
  localparam logic [7:0]        FULL_SCALE     = 8'd255;

  typedef enum logic [2:0] {
    ACT_SILENT     = 3'd0,
    ACT_BADID      = 3'd1,
    ACT_UPDATED    = 3'd2,
    ACT_SUPPRESSED = 3'd3,
    ACT_FREE       = 3'd4,
    ACT_STOLEN     = 3'd5,
    ACT_NOSLOT     = 3'd6,
    ACT_RELEASED   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    CFG_DUCK   = 3'd0,
    CFG_EFFECT = 3'd1,
    CFG_MUSIC  = 3'd2,
    CFG_GAIN   = 3'd3,
    CFG_STEREO = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_PREP,
    ST_DIV,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [31:0]        sound;
    logic [15:0]        frame;
    logic signed [15:0] prio;
    logic [15:0]        vol;
    logic [16:0]        pitch;
    logic [6:0]         pan;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== src/sound_voice_allocator_top.sv =====
// Release, silent and bad-id requests give their result in the cycle after the transfer;
// other play requests pass through 3 multiplies, 1 reciprocal multiply, 1 add, the slot
// scan, 1 decision and 1 result register; busy is high from ST_MUL1 through ST_DECIDE.
// A new request is taken only while busy is low, so a play request finishes before the next.
// Reset (synchronous, rst_n low): all slots free, config at defaults, no result pending.
// Slot memory: sva_ram, one read per cycle during the scan; depends on sva_pkg.
`timescale 1ns / 1ps

module sound_voice_allocator_top
  import sva_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic signed [31:0] in_sound_id,
  input  logic signed [15:0] in_priority_req,
  input  logic [15:0]        in_pitch,
  input  logic [15:0]        in_volume,
  input  logic [6:0]         in_pan,
  input  logic               in_keyed,
  input  logic               in_is_music,
  input  logic [15:0]        in_frame_stamp,
  input  logic [2:0]         in_release_slot,
  // result channel
  output logic               out_valid,
  output logic [2:0]         out_action,
  output logic [2:0]         out_slot_index,
  output logic [15:0]        out_final_volume,
  output logic signed [15:0] out_final_priority,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  state_t state_r, state_nxt;

  // configuration registers
  logic [7:0]  duck_r, effect_vol_r, music_vol_r;
  logic [15:0] gain_r;
  logic        stereo_r;

  // slot flags kept in flops
  logic [NUM_VOICES-1:0] busy_r, skeyed_r;

  // request held for the duration of the item
  logic [31:0]        id_r;
  logic signed [15:0] pri_r;
  logic [16:0]        pitch2_r;
  logic [6:0]         pan_r;
  logic               req_keyed_r;
  logic [15:0]        frame_r;
  logic [15:0]        vol_r;
  logic [7:0]         cat_r, duckf_r;

  // scaling chain
  logic [23:0] p1_r;
  logic [31:0] p2_r;
  logic [47:0] n_r;
  logic        sat_r;
  logic [31:0] mq_r;
  logic [57:0] prod_r;
  logic [15:0] q_r;

  // scan
  logic [CNT_W-1:0]   cnt_r;
  logic               dv_r;
  logic [IDX_W-1:0]   didx_r;
  logic               match_r, free_r, steal_r;
  logic [IDX_W-1:0]   match_idx_r, free_idx_r, steal_idx_r;
  logic [15:0]        match_vol_r, match_frame_r;
  logic signed [15:0] low_r;

  // results
  logic               out_valid_r;
  action_t            out_action_r;
  logic [2:0]         out_slot_r;
  logic [15:0]        out_vol_r;
  logic signed [15:0] out_pri_r;

  // memory ports
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  slot_entry_t      wr_entry, rd_entry;
  logic [ENTRY_W-1:0] rd_data;

  logic       accept;
  logic [7:0] acc_cat, acc_duckf;
  logic       acc_zero, acc_quick;

  // decision
  logic [15:0]      fvol;
  logic             suppress;
  action_t          dec_action;
  logic [IDX_W-1:0] dec_slot;
  logic             dec_write, dec_claim;

  // reciprocal division
  logic [39:0] m_val;
  logic [64:0] qsum;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign acc_cat   = in_is_music ? music_vol_r : effect_vol_r;
  assign acc_duckf = in_keyed ? 8'(FULL_SCALE - duck_r) : FULL_SCALE;
  assign acc_zero  = (in_volume == 16'd0) || (acc_cat == 8'd0) || (acc_duckf == 8'd0);
  assign acc_quick = in_func || acc_zero || in_sound_id[31];

  assign m_val = n_r[47:8];
  assign qsum  = {1'b0, mq_r, 32'd0} + 65'(prod_r);

  assign rd_entry = slot_entry_t'(rd_data);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept && !acc_quick) state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_MUL3;
      ST_MUL3:   state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == CNT_W'(NUM_VOICES)) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // decide the outcome from the scan results
  always_comb begin
    fvol       = sat_r ? 16'hFFFF : q_r;
    suppress   = !sat_r && (match_vol_r > q_r) && (match_frame_r == frame_r);
    dec_action = ACT_NOSLOT;
    dec_slot   = '0;
    dec_write  = 1'b0;
    dec_claim  = 1'b0;
    if (req_keyed_r && match_r) begin
      if (suppress) begin
        dec_action = ACT_SUPPRESSED;
      end else begin
        dec_action = ACT_UPDATED;
        dec_slot   = match_idx_r;
        dec_write  = 1'b1;
      end
    end else if (free_r) begin
      dec_action = ACT_FREE;
      dec_slot   = free_idx_r;
      dec_write  = 1'b1;
      dec_claim  = 1'b1;
    end else if (steal_r) begin
      dec_action = ACT_STOLEN;
      dec_slot   = steal_idx_r;
      dec_write  = 1'b1;
      dec_claim  = 1'b1;
    end
  end

  // state machine outputs: memory access and busy
  always_comb begin
    busy     = (state_r != ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = cnt_r[IDX_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = dec_slot;
    wr_entry = '{sound: id_r, frame: frame_r, prio: pri_r, vol: fvol,
                 pitch: pitch2_r, pan: pan_r};
    case (state_r)
      ST_SCAN:   rd_en = (cnt_r < CNT_W'(NUM_VOICES));
      ST_DECIDE: wr_en = dec_write;
      default:   rd_en = 1'b0;
    endcase
  end

  sva_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_VOICES)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      duck_r       <= 8'd0;
      effect_vol_r <= FULL_SCALE;
      music_vol_r  <= FULL_SCALE;
      gain_r       <= 16'd256;
      stereo_r     <= 1'b1;
      busy_r       <= '0;
      skeyed_r     <= '0;
      out_valid_r  <= 1'b0;
      dv_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      dv_r        <= rd_en;

      // take a configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DUCK:   duck_r       <= cfg_data[7:0];
          CFG_EFFECT: effect_vol_r <= cfg_data[7:0];
          CFG_MUSIC:  music_vol_r  <= cfg_data[7:0];
          CFG_GAIN:   gain_r       <= cfg_data;
          CFG_STEREO: stereo_r     <= cfg_data[0];
          default:    ;
        endcase
      end

      // release frees the slot at once
      if (accept && in_func && (32'(in_release_slot) < NUM_VOICES)) begin
        busy_r[IDX_W'(in_release_slot)]   <= 1'b0;
        skeyed_r[IDX_W'(in_release_slot)] <= 1'b0;
      end
      if (accept && acc_quick) begin
        out_valid_r <= 1'b1;
      end

      // claim a slot on a fresh allocation
      if (state_r == ST_DECIDE) begin
        out_valid_r <= 1'b1;
        if (dec_claim) begin
          busy_r[dec_slot]   <= 1'b1;
          skeyed_r[dec_slot] <= req_keyed_r;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // capture the request
    if (accept) begin
      id_r        <= in_sound_id;
      pri_r       <= in_is_music ? MUSIC_PRIORITY : in_priority_req;
      pitch2_r    <= {in_pitch, 1'b0};
      pan_r       <= stereo_r ? in_pan : PAN_CENTRE;
      req_keyed_r <= in_keyed;
      frame_r     <= in_frame_stamp;
      vol_r       <= in_volume;
      cat_r       <= acc_cat;
      duckf_r     <= acc_duckf;
      out_slot_r  <= 3'd0;
      out_vol_r   <= 16'd0;
      out_pri_r   <= 16'sd0;
      if (in_func) begin
        out_action_r <= ACT_RELEASED;
        out_slot_r   <= in_release_slot;
      end else if (acc_zero) begin
        out_action_r <= ACT_SILENT;
      end else begin
        out_action_r <= ACT_BADID;
      end
    end

    // scaling multiplies, one per cycle
    p1_r <= vol_r * cat_r;
    p2_r <= p1_r * duckf_r;
    n_r  <= p2_r * gain_r;

    // divide by 65025 through the reciprocal: multiply, then add and shift
    if (state_r == ST_PREP) begin
      sat_r  <= m_val >= SAT_LIMIT;
      mq_r   <= m_val[31:0];
      prod_r <= m_val[31:0] * RECIP_FRAC;
    end else if (state_r == ST_DIV) begin
      q_r <= qsum[63:48];
    end

    // scan set-up
    if (state_r == ST_PREP) begin
      cnt_r   <= '0;
      match_r <= 1'b0;
      free_r  <= 1'b0;
      steal_r <= 1'b0;
      low_r   <= pri_r;
    end else if (state_r == ST_SCAN) begin
      cnt_r  <= cnt_r + 1'b1;
      didx_r <= cnt_r[IDX_W-1:0];
    end

    // fold one slot per cycle into the scan results
    if (dv_r) begin
      if (!match_r && skeyed_r[didx_r] && (rd_entry.sound == id_r)) begin
        match_r       <= 1'b1;
        match_idx_r   <= didx_r;
        match_vol_r   <= rd_entry.vol;
        match_frame_r <= rd_entry.frame;
      end
      if (!free_r && !busy_r[didx_r]) begin
        free_r     <= 1'b1;
        free_idx_r <= didx_r;
      end
      if (rd_entry.prio < low_r) begin
        low_r       <= rd_entry.prio;
        steal_r     <= 1'b1;
        steal_idx_r <= didx_r;
      end
    end

    // hold the outcome for the strobe
    if (state_r == ST_DECIDE) begin
      out_action_r <= dec_action;
      out_slot_r   <= dec_write ? 3'(dec_slot) : 3'd0;
      out_vol_r    <= dec_write ? fvol : 16'd0;
      out_pri_r    <= dec_write ? pri_r : 16'sd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_slot_index     = out_slot_r;
  assign out_final_volume   = out_vol_r;
  assign out_final_priority = out_pri_r;

endmodule

// ===== src/sva_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module sva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sva_checker.sv =====
// Port-level checker for the sound voice allocator, bound to the top level.
// Depends on sva_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sva_checker
  import sva_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_func,
  input logic [15:0]        in_volume,
  input logic               out_valid,
  input logic [2:0]         out_action,
  input logic [2:0]         out_slot_index,
  input logic [15:0]        out_final_volume,
  input logic signed [15:0] out_final_priority
);

  logic in_xfer, rel_xfer, zero_xfer, no_slot_res, empty_payload;

  assign in_xfer       = start && !busy;
  assign rel_xfer      = in_xfer && in_func;
  assign zero_xfer     = in_xfer && !in_func && (in_volume == 16'd0);
  assign no_slot_res   = out_valid && (out_action == ACT_SILENT || out_action == ACT_BADID ||
                         out_action == ACT_SUPPRESSED || out_action == ACT_NOSLOT);
  assign empty_payload = (out_slot_index == 3'd0) && (out_final_volume == 16'd0) &&
                         (out_final_priority == 16'sd0);

  // release answers in the next cycle
  `SVA_ASSERT_NEXT(a_release_next, rel_xfer, out_valid && (out_action == ACT_RELEASED), "late release")

  // zero volume is silent in the next cycle
  `SVA_ASSERT_NEXT(a_silent_next, zero_xfer, out_valid && (out_action == ACT_SILENT), "late silent")

  // results without a slot carry zero payload
  `SVA_ASSERT(a_empty_payload, no_slot_res |-> empty_payload, "payload not cleared")

  // busy rises only after a transfer
  `SVA_ASSERT(a_busy_cause, $rose(busy) |-> $past(start), "busy without start")

endmodule

bind sound_voice_allocator_top sva_checker u_sva_checker (.*);
